// ===== hdl/dcpm_pkg.sv =====
`default_nettype none

package dcpm_pkg;

   // Field widths of the channels
   localparam int SAMPLE_WIDTH   = 16;
   localparam int PEAK_WIDTH     = 16;
   localparam int COUNT_WIDTH    = 12;
   localparam int OFFSET_WIDTH   = 16;

   // Storage sizes
   localparam int CAPTURE_DEPTH  = 2048;
   localparam int BLOCK_DEPTH    = 256;
   localparam int WINDOW_LENGTH  = 1024;

   // Derived widths
   localparam int BLOCK_AW       = $clog2(BLOCK_DEPTH);
   localparam int FILL_WIDTH     = $clog2(BLOCK_DEPTH + 1);
   localparam int SUM_WIDTH      = SAMPLE_WIDTH + FILL_WIDTH;
   localparam int MAG_WIDTH      = SUM_WIDTH - 1;
   localparam int DIV_CW         = $clog2(MAG_WIDTH + 1);
   localparam int CAP_AW         = $clog2(CAPTURE_DEPTH);
   localparam int TOTAL_WIDTH    = $clog2(CAPTURE_DEPTH + 1);
   localparam int TSUM_WIDTH     = ((TOTAL_WIDTH > FILL_WIDTH) ? TOTAL_WIDTH : FILL_WIDTH) + 1;
   localparam int SCAN_LENGTH    = (WINDOW_LENGTH > CAPTURE_DEPTH) ? CAPTURE_DEPTH : WINDOW_LENGTH;
   localparam int SCAN_CW        = $clog2(SCAN_LENGTH);

   // Stream data widths, padded to whole bytes
   localparam int REQ_DATA_WIDTH = ((SAMPLE_WIDTH + 7) / 8) * 8;
   localparam int RSP_BITS       = PEAK_WIDTH + COUNT_WIDTH + OFFSET_WIDTH;
   localparam int RSP_DATA_WIDTH = ((RSP_BITS + 7) / 8) * 8;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_COPY_RD,
      ST_COPY_WR,
      ST_CLOSE,
      ST_SCAN,
      ST_DRAIN,
      ST_RESULT
   } dcpm_state_type;

   typedef struct packed {
      logic sample_write;
      logic div_start;
      logic copy_read;
      logic copy_write;
      logic block_close;
      logic scan_step;
      logic result_load;
   } dcpm_cmd_type;

   typedef struct packed {
      logic block_full;
      logic div_busy;
      logic copy_last;
      logic scan_last;
   } dcpm_status_type;

endpackage

`default_nettype wire

// ===== hdl/dcpm_div.sv =====
`default_nettype none

module dcpm_div (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   input  wire logic signed [dcpm_pkg::SUM_WIDTH-1:0] dividend,
   input  wire logic [dcpm_pkg::FILL_WIDTH-1:0]       divisor,
   output logic                                       busy,
   output logic signed [dcpm_pkg::OFFSET_WIDTH-1:0]   quotient
);
   import dcpm_pkg::*;

   logic                  busy_ff, busy_in;
   logic [DIV_CW-1:0]     cnt_ff, cnt_in;
   logic [FILL_WIDTH-1:0] rem_ff, rem_in;
   logic [MAG_WIDTH-1:0]  quo_ff, quo_in;
   logic [FILL_WIDTH-1:0] den_ff, den_in;
   logic                  neg_ff, neg_in;
   logic [FILL_WIDTH:0]   trial;
   logic [SUM_WIDTH-1:0]  abs_sum;
   logic [MAG_WIDTH-1:0]  signed_quo;

   // Magnitude of the dividend; the most negative sum still fits
   assign abs_sum = dividend[SUM_WIDTH-1] ? (~dividend + 1'b1) : dividend;
   assign trial   = {rem_ff, quo_ff[MAG_WIDTH-1]};

   // Restoring division, one quotient bit per cycle
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CW'(MAG_WIDTH);
         rem_in  = '0;
         quo_in  = abs_sum[MAG_WIDTH-1:0];
         den_in  = divisor;
         neg_in  = dividend[SUM_WIDTH-1];
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = FILL_WIDTH'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[MAG_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = trial[FILL_WIDTH-1:0];
            quo_in = {quo_ff[MAG_WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   // Apply the sign; truncation toward zero falls out of the magnitude division
   assign signed_quo = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
   assign quotient   = signed_quo[OFFSET_WIDTH-1:0];
   assign busy       = busy_ff;

endmodule

`default_nettype wire

// ===== hdl/dcpm_datapath.sv =====
`default_nettype none

module dcpm_datapath (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire dcpm_pkg::dcpm_cmd_type                cmd,
   input  wire logic [dcpm_pkg::SAMPLE_WIDTH-1:0]     sample,
   output dcpm_pkg::dcpm_status_type                  status,
   output logic [dcpm_pkg::PEAK_WIDTH-1:0]            peak_magnitude,
   output logic [dcpm_pkg::COUNT_WIDTH-1:0]           filled_count,
   output logic [dcpm_pkg::OFFSET_WIDTH-1:0]          dc_offset
);
   import dcpm_pkg::*;

   // Storage
   logic [SAMPLE_WIDTH-1:0] block_store [BLOCK_DEPTH];
   logic [SAMPLE_WIDTH-1:0] capture_store [CAPTURE_DEPTH];

   // Block accumulation and bookkeeping
   logic signed [SUM_WIDTH-1:0] sum_ff, sum_in;
   logic [FILL_WIDTH-1:0]       fill_ff, fill_in;
   logic [BLOCK_AW-1:0]         copy_idx_ff, copy_idx_in;
   logic [CAP_AW-1:0]           head_ff, head_in;
   logic [TOTAL_WIDTH-1:0]      total_ff, total_in;
   logic [OFFSET_WIDTH-1:0]     offset_ff, offset_in;
   logic [SAMPLE_WIDTH-1:0]     blk_rd_ff;

   // Window scan
   logic [SCAN_CW-1:0]          scan_k_ff, scan_k_in;
   logic [SAMPLE_WIDTH-1:0]     cap_rd_ff;
   logic                        written_ff;
   logic                        scan_vld_ff;
   logic [PEAK_WIDTH-1:0]       peak_ff, peak_in;

   // Result register
   logic [PEAK_WIDTH-1:0]       rsp_peak_ff;
   logic [COUNT_WIDTH-1:0]      rsp_count_ff;
   logic [OFFSET_WIDTH-1:0]     rsp_offset_ff;

   logic signed [OFFSET_WIDTH-1:0] quotient;
   logic                           div_busy;
   logic [TSUM_WIDTH-1:0]          total_sum;
   logic [CAP_AW-1:0]              scan_addr;
   logic [SAMPLE_WIDTH-1:0]        scan_val;
   logic [PEAK_WIDTH-1:0]          scan_mag;
   logic [SAMPLE_WIDTH-1:0]        dc_free;

   dcpm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (sum_ff),
      .divisor  (fill_ff),
      .busy     (div_busy),
      .quotient (quotient)
   );

   assign total_sum = TSUM_WIDTH'(total_ff) + TSUM_WIDTH'(fill_ff);
   assign scan_addr = head_ff - CAP_AW'(1) - CAP_AW'(scan_k_ff);
   assign scan_val  = written_ff ? cap_rd_ff : '0;
   assign scan_mag  = scan_val[SAMPLE_WIDTH-1] ? PEAK_WIDTH'(~scan_val + 1'b1)
                                               : PEAK_WIDTH'(scan_val);
   assign dc_free   = blk_rd_ff - SAMPLE_WIDTH'(quotient);

   // Next state of the bookkeeping registers
   always_comb begin
      sum_in      = sum_ff;
      fill_in     = fill_ff;
      copy_idx_in = copy_idx_ff;
      head_in     = head_ff;
      total_in    = total_ff;
      offset_in   = offset_ff;
      scan_k_in   = scan_k_ff;
      peak_in     = peak_ff;
      if (cmd.sample_write) begin
         sum_in  = sum_ff + {{(SUM_WIDTH-SAMPLE_WIDTH){sample[SAMPLE_WIDTH-1]}}, sample};
         fill_in = fill_ff + 1'b1;
      end
      if (cmd.copy_write) begin
         copy_idx_in = copy_idx_ff + 1'b1;
         head_in     = head_ff + 1'b1;
      end
      if (cmd.block_close) begin
         sum_in      = '0;
         fill_in     = '0;
         copy_idx_in = '0;
         offset_in   = OFFSET_WIDTH'(quotient);
         scan_k_in   = '0;
         peak_in     = '0;
         if (total_sum > TSUM_WIDTH'(CAPTURE_DEPTH)) begin
            total_in = TOTAL_WIDTH'(CAPTURE_DEPTH);
         end else begin
            total_in = TOTAL_WIDTH'(total_sum);
         end
      end
      if (cmd.scan_step) begin
         scan_k_in = scan_k_ff + 1'b1;
      end
      if (scan_vld_ff && (scan_mag > peak_ff)) begin
         peak_in = scan_mag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff      <= '0;
         fill_ff     <= '0;
         copy_idx_ff <= '0;
         head_ff     <= '0;
         total_ff    <= '0;
         offset_ff   <= '0;
         scan_k_ff   <= '0;
         peak_ff     <= '0;
         scan_vld_ff <= 1'b0;
      end else begin
         sum_ff      <= sum_in;
         fill_ff     <= fill_in;
         copy_idx_ff <= copy_idx_in;
         head_ff     <= head_in;
         total_ff    <= total_in;
         offset_ff   <= offset_in;
         scan_k_ff   <= scan_k_in;
         peak_ff     <= peak_in;
         scan_vld_ff <= cmd.scan_step;
      end
   end

   // Block store: write incoming samples, read back during the copy
   always_ff @(posedge clock) begin
      if (cmd.sample_write) begin
         block_store[fill_ff[BLOCK_AW-1:0]] <= sample;
      end
      if (cmd.copy_read) begin
         blk_rd_ff <= block_store[copy_idx_ff];
      end
   end

   // Capture store: append DC-free samples, read newest-first during the scan.
   // Slots at or above the capture count were never written and read as zero.
   always_ff @(posedge clock) begin
      if (cmd.copy_write) begin
         capture_store[head_ff] <= dc_free;
      end
      if (cmd.scan_step) begin
         cap_rd_ff  <= capture_store[scan_addr];
         written_ff <= (TOTAL_WIDTH'(scan_addr) < total_ff);
      end
   end

   // Hold the result for the output channel
   always_ff @(posedge clock) begin
      if (cmd.result_load) begin
         rsp_peak_ff   <= peak_ff;
         rsp_count_ff  <= COUNT_WIDTH'(total_ff);
         rsp_offset_ff <= offset_ff;
      end
   end

   assign status.block_full = (fill_ff == FILL_WIDTH'(BLOCK_DEPTH - 1));
   assign status.div_busy   = div_busy;
   assign status.copy_last  = (FILL_WIDTH'(copy_idx_ff) == (fill_ff - 1'b1));
   assign status.scan_last  = (scan_k_ff == SCAN_CW'(SCAN_LENGTH - 1));

   assign peak_magnitude = rsp_peak_ff;
   assign filled_count   = rsp_count_ff;
   assign dc_offset      = rsp_offset_ff;

   a_total_bounded: assert property (@(posedge clock) disable iff (reset)
      total_ff <= TOTAL_WIDTH'(CAPTURE_DEPTH))
      else $error("capture count above capture depth");

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_WIDTH'(BLOCK_DEPTH))
      else $error("block fill above block depth");

   a_copy_in_block: assert property (@(posedge clock) disable iff (reset)
      cmd.copy_write |-> (FILL_WIDTH'(copy_idx_ff) < fill_ff))
      else $error("copy index past the end of the block");

   a_div_idle_in_copy: assert property (@(posedge clock) disable iff (reset)
      (cmd.copy_read || cmd.copy_write || cmd.block_close) |-> !div_busy)
      else $error("offset used while the divider is still running");

endmodule

`default_nettype wire

// ===== hdl/dcpm_ctrl.sv =====
`default_nettype none

module dcpm_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   input  wire logic                       req_tlast,
   input  wire logic                       req_tuser,
   output logic                            req_tready,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   input  wire dcpm_pkg::dcpm_status_type  status,
   output dcpm_pkg::dcpm_cmd_type          cmd
);
   import dcpm_pkg::*;

   dcpm_state_type state_ff, state_in;
   logic           update_ff, update_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         update_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         update_ff    <= update_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Sequence sample intake, block division, copy, window scan and result
   always_comb begin
      state_in   = state_ff;
      update_in  = update_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.sample_write = 1'b1;
               update_in        = req_tuser;
               if (req_tlast || req_tuser || status.block_full) begin
                  state_in = ST_DIV_GO;
               end
            end
         end
         ST_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (!status.div_busy) begin
               state_in = ST_COPY_RD;
            end
         end
         ST_COPY_RD: begin
            cmd.copy_read = 1'b1;
            state_in      = ST_COPY_WR;
         end
         ST_COPY_WR: begin
            cmd.copy_write = 1'b1;
            state_in       = status.copy_last ? ST_CLOSE : ST_COPY_RD;
         end
         ST_CLOSE: begin
            cmd.block_close = 1'b1;
            state_in        = update_ff ? ST_SCAN : ST_IDLE;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            // Wait for the output register to free up
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.result_load = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output valid: set on load, drop after the transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.result_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.result_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwritten before its transfer");

   a_scan_only_after_update: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> update_ff)
      else $error("window scan without an update end");

endmodule

`default_nettype wire

// ===== hdl/block_dc_removal_peak_meter_core.sv =====
// Block-mean DC removal with a window peak meter.
// Input channel (req_): one signed 16-bit microphone sample per transfer.
// req_tlast marks the last sample of a block, req_tuser the last sample of
// an update (which also ends the block). A block also ends on its 256th sample.
// Output channel (rsp_): one result per update: the largest magnitude over the
// newest 1024 DC-free captured samples, the saturating capture count and the
// mean removed from the latest block.
// A block end starts the serial divider for the mean, then makes one store
// read and one store write per sample in the block, then closes the block.
// An update end adds the window scan over the newest 1024 capture slots, one
// capture store read a cycle, and a drain step before the result is loaded.
// Reset clears the capture count, offset and block state; capture slots never
// written read as zero, so no clearing pass is needed.
// The result sits in an output register; new samples are accepted while it
// waits, and a following result waits until rsp_tready takes the first.
`default_nettype none

module block_dc_removal_peak_meter_core (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   input  wire logic [dcpm_pkg::REQ_DATA_WIDTH-1:0]    req_tdata,  // sample
   input  wire logic                                   req_tlast,  // block_end
   input  wire logic                                   req_tuser,  // update_end
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   output logic [dcpm_pkg::RSP_DATA_WIDTH-1:0]         rsp_tdata   // peak_magnitude,
                                                                   // filled_count, dc_offset
);
   import dcpm_pkg::*;

   dcpm_cmd_type             cmd;
   dcpm_status_type          status;
   logic [PEAK_WIDTH-1:0]    peak_magnitude;
   logic [COUNT_WIDTH-1:0]   filled_count;
   logic [OFFSET_WIDTH-1:0]  dc_offset;

   dcpm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   dcpm_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sample         (req_tdata[SAMPLE_WIDTH-1:0]),
      .status         (status),
      .peak_magnitude (peak_magnitude),
      .filled_count   (filled_count),
      .dc_offset      (dc_offset)
   );

   // Pack the result fields, lowest field first, zero padded
   assign rsp_tdata = RSP_DATA_WIDTH'({dc_offset, filled_count, peak_magnitude});

endmodule

`default_nettype wire

// ===== dv/dc_meter_checker.sv =====
module dc_meter_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [dcpm_pkg::REQ_DATA_WIDTH-1:0] req_tdata,   // sample
   input  logic                                req_tlast,   // block_end
   input  logic                                req_tuser,   // update_end
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [dcpm_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,   // peak_magnitude,
                                                            // filled_count, dc_offset
   output int                                  fail_count,
   output int                                  readings_pending
);
   import dcpm_pkg::*;

   // One meter reading, last field in the lowest bits of the struct
   typedef struct packed {
      logic signed [OFFSET_WIDTH-1:0] offset;
      logic [COUNT_WIDTH-1:0]         count;
      logic [PEAK_WIDTH-1:0]          peak;
   } meter_reading_type;

   meter_reading_type expected_readings[$];

   // Predicted block and capture state
   logic [SAMPLE_WIDTH-1:0] blk_mem [BLOCK_DEPTH];
   longint                  blk_sum;
   int                      blk_fill;
   logic [SAMPLE_WIDTH-1:0] cap_mem [CAPTURE_DEPTH];
   int                      cap_head;
   int                      cap_total;
   logic [OFFSET_WIDTH-1:0] last_mean;

   // Remove the block mean and append the block to the capture ring
   function automatic void close_block();
      longint mean;
      longint diff;
      int     i;
      if (blk_fill == 0) return;
      mean = blk_sum / longint'(blk_fill);
      for (i = 0; i < blk_fill; i++) begin
         diff = longint'($signed(blk_mem[i])) - mean;
         cap_mem[cap_head] = diff[SAMPLE_WIDTH-1:0];
         cap_head = (cap_head + 1) % CAPTURE_DEPTH;
      end
      cap_total += blk_fill;
      if (cap_total > CAPTURE_DEPTH) cap_total = CAPTURE_DEPTH;
      last_mean = mean[OFFSET_WIDTH-1:0];
      blk_sum = 0;
      blk_fill = 0;
   endfunction

   // Largest magnitude over the newest window of captured samples
   function automatic logic [PEAK_WIDTH-1:0] window_peak();
      int k;
      int idx;
      int v;
      int mag;
      mag = 0;
      for (k = 1; k <= SCAN_LENGTH; k++) begin
         idx = (cap_head + CAPTURE_DEPTH - k) % CAPTURE_DEPTH;
         v = $signed(cap_mem[idx]);
         if (v < 0) v = -v;
         if (v > mag) mag = v;
      end
      return mag[PEAK_WIDTH-1:0];
   endfunction

   function automatic void check_field(string field, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
         fail_count++;
      end
   endfunction

   initial begin
      fail_count = 0;
      readings_pending = 0;
   end

   always @(posedge clock) begin : predict_and_compare
      meter_reading_type got;
      meter_reading_type want;
      if (reset) begin
         // Clear the predicted state
         foreach (cap_mem[i]) cap_mem[i] = '0;
         foreach (blk_mem[i]) blk_mem[i] = '0;
         blk_sum = 0;
         blk_fill = 0;
         cap_head = 0;
         cap_total = 0;
         last_mean = '0;
         expected_readings.delete();
      end else begin
         // Compare a result transfer with the oldest expected reading
         if (rsp_tvalid && rsp_tready) begin
            got = meter_reading_type'(rsp_tdata[RSP_BITS-1:0]);
            if (expected_readings.size() == 0) begin
               $display("%0t: unexpected reading, expected none, got peak %0d count %0d offset %0d",
                        $time, got.peak, got.count, got.offset);
               fail_count++;
            end else begin
               want = expected_readings.pop_front();
               check_field("peak_magnitude", want.peak, got.peak);
               check_field("filled_count", want.count, got.count);
               check_field("dc_offset", want.offset, got.offset);
            end
         end
         // Absorb a sample transfer, close the block and predict a reading
         if (req_tvalid && req_tready) begin
            if (blk_fill < BLOCK_DEPTH) begin
               blk_mem[blk_fill] = req_tdata[SAMPLE_WIDTH-1:0];
               blk_sum += longint'($signed(req_tdata[SAMPLE_WIDTH-1:0]));
               blk_fill++;
            end
            if (req_tlast || req_tuser || blk_fill >= BLOCK_DEPTH) close_block();
            if (req_tuser) begin
               want.peak = window_peak();
               want.count = cap_total[COUNT_WIDTH-1:0];
               want.offset = last_mean;
               expected_readings.push_back(want);
            end
         end
      end
      readings_pending = expected_readings.size();
   end

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
   import dcpm_pkg::*;

   localparam int CYCLE_LIMIT  = 4_000_000;
   localparam int DRAIN_CYCLES = 2000;

   typedef enum int {
      STYLE_UNIFORM,
      STYLE_BIASED,
      STYLE_RAIL
   } block_style_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata = '0;   // sample
   logic                      req_tlast = 1'b0; // block_end
   logic                      req_tuser = 1'b0; // update_end
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;        // peak_magnitude, filled_count, dc_offset

   int fail_count;
   int readings_pending;
   int cycle_count = 0;
   int samples_sent = 0;
   int updates_sent = 0;
   bit req_steady = 1'b0;
   bit rsp_steady = 1'b0;

   block_dc_removal_peak_meter_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   dc_meter_checker meter_check (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tlast        (req_tlast),
      .req_tuser        (req_tuser),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .fail_count       (fail_count),
      .readings_pending (readings_pending)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Hold each sample until its transfer, after a random gap
   task automatic send_sample(input logic [SAMPLE_WIDTH-1:0] s, input bit bend, input bit uend);
      int gap;
      if ($urandom_range(0, 31) == 0) req_steady = !req_steady;
      gap = req_steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_WIDTH'(s);
      req_tlast  <= bend;
      req_tuser  <= uend;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      samples_sent++;
      if (uend) updates_sent++;
   endtask

   // Send one block of samples, marking its last sample as asked
   task automatic play_block(input int length, input block_style_type style,
                             input bit mark_block, input bit mark_update);
      logic [SAMPLE_WIDTH-1:0] bias;
      logic [SAMPLE_WIDTH-1:0] s;
      int n;
      bias = SAMPLE_WIDTH'($urandom);
      for (n = 0; n < length; n++) begin
         case (style)
            STYLE_UNIFORM: s = SAMPLE_WIDTH'($urandom);
            STYLE_BIASED:  s = bias + SAMPLE_WIDTH'($urandom_range(0, 255)) - 16'd128;
            default:       s = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
         endcase
         send_sample(s, mark_block && (n == length - 1), mark_update && (n == length - 1));
      end
   endtask

   // Updates of one to three mostly short blocks, now and then an overlong one
   task automatic random_burst(input int item_goal, input int update_goal);
      int first_item;
      int first_update;
      int blocks;
      int b;
      int len;
      block_style_type style;
      first_item = samples_sent;
      first_update = updates_sent;
      while (samples_sent - first_item < item_goal ||
             updates_sent - first_update < update_goal) begin
         blocks = $urandom_range(1, 3);
         for (b = 0; b < blocks; b++) begin
            len = ($urandom_range(0, 59) == 0) ? $urandom_range(200, 300) : $urandom_range(1, 6);
            style = block_style_type'($urandom_range(0, 2));
            if (b == blocks - 1) play_block(len, style, $urandom_range(0, 1) == 1, 1'b1);
            else play_block(len, style, $urandom_range(0, 3) != 0, 1'b0);
         end
      end
   endtask

   // Accept results after a random stall, with stall-free stretches
   initial begin : rsp_sink
      int stall;
      forever begin
         if ($urandom_range(0, 15) == 0) rsp_steady = !rsp_steady;
         stall = rsp_steady ? 0 : $urandom_range(0, 6);
         rsp_tready <= (stall == 0);
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         if (stall > 0) begin
            repeat (stall - 1) @(posedge clock);
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Single-sample update of zero
      send_sample(16'h0000, 1'b1, 1'b1);
      // Rails cancel; update end alone closes the block, most negative peak
      send_sample(16'h7FFF, 1'b0, 1'b0);
      send_sample(16'h8000, 1'b0, 1'b0);
      send_sample(16'h0001, 1'b0, 1'b1);
      // Mean pushes the positive rail past 16 bits; then a one-sample block
      send_sample(16'h7FFF, 1'b0, 1'b0);
      send_sample(16'h8000, 1'b0, 1'b0);
      send_sample(16'h8000, 1'b1, 1'b0);
      send_sample(16'hFFFF, 1'b1, 1'b1);
      // Block of the most negative value only
      send_sample(16'h8000, 1'b0, 1'b0);
      send_sample(16'h8000, 1'b0, 1'b0);
      send_sample(16'h8000, 1'b1, 1'b1);
      // Means of odd negative sums truncate toward zero
      send_sample(16'd5, 1'b0, 1'b0);
      send_sample(-16'sd6, 1'b1, 1'b0);
      send_sample(-16'sd5, 1'b0, 1'b0);
      send_sample(-16'sd6, 1'b1, 1'b1);
      // Block end and update end on separate blocks
      send_sample(16'd7, 1'b1, 1'b0);
      send_sample(-16'sd7, 1'b0, 1'b1);
      send_sample(16'h7FFF, 1'b0, 1'b0);
      send_sample(16'h7FFF, 1'b1, 1'b0);
      send_sample(16'h0000, 1'b0, 1'b1);

      random_burst(150, 10);

      // Full block without markers closes on its own, then a short update
      play_block(BLOCK_DEPTH, block_style_type'($urandom_range(0, 2)), 1'b0, 1'b0);
      play_block($urandom_range(1, 4), block_style_type'($urandom_range(0, 2)), 1'b0, 1'b1);

      random_burst(150, 10);

      // Drain outstanding readings, then watch for strays
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (readings_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (readings_pending != 0)
         $display("%0t: %0d expected readings never arrived", $time, readings_pending);
      if (fail_count == 0 && readings_pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
